/* rtl/plap_pkg.sv */
// Shared constants, control word type and microcode table for the Laplacian stencil.
`default_nettype none
package plap_pkg;

  localparam int GridSize = 64;
  localparam int IdxW     = $clog2(GridSize);
  localparam int AddrW    = 2 * IdxW;
  localparam int Depth    = GridSize * GridSize;
  localparam int SampleW  = 24;
  localparam int AccW     = 32;
  localparam int ScaleW   = 32;
  localparam int ProdW    = 64;
  localparam int ResW     = 32;
  localparam int OffW     = 3;
  localparam int PcW      = 4;
  localparam int RndShift = 16;

  localparam logic [PcW-1:0] LastStep = PcW'(11);
  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(65536);

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    W_NONE,
    W_NEG60,
    W_POS16,
    W_NEG1
  } weight_e;

  typedef struct packed {
    logic                   dispatch;  // first step: store writes and finishes
    logic                   rd_en;
    logic signed [OffW-1:0] row_off;
    logic signed [OffW-1:0] col_off;
    weight_e                weight;    // applied to the word read by the previous step
    logic                   acc_clr;
    logic                   mul_en;
    logic                   last;
  } ctrl_t;

  // Query program: nine reads with the accumulation trailing them, multiply, round.
  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t c;
    c = '0;
    unique case (pc)
      4'd0: begin
        c.dispatch = 1'b1; c.rd_en = 1'b1;
      end
      4'd1: begin
        c.rd_en = 1'b1; c.row_off = 3'sd1; c.weight = W_NEG60; c.acc_clr = 1'b1;
      end
      4'd2: begin
        c.rd_en = 1'b1; c.row_off = 3'sd2; c.weight = W_POS16;
      end
      4'd3: begin
        c.rd_en = 1'b1; c.row_off = -3'sd1; c.weight = W_NEG1;
      end
      4'd4: begin
        c.rd_en = 1'b1; c.row_off = -3'sd2; c.weight = W_POS16;
      end
      4'd5: begin
        c.rd_en = 1'b1; c.col_off = 3'sd1; c.weight = W_NEG1;
      end
      4'd6: begin
        c.rd_en = 1'b1; c.col_off = 3'sd2; c.weight = W_POS16;
      end
      4'd7: begin
        c.rd_en = 1'b1; c.col_off = -3'sd1; c.weight = W_NEG1;
      end
      4'd8: begin
        c.rd_en = 1'b1; c.col_off = -3'sd2; c.weight = W_POS16;
      end
      4'd9: begin
        c.weight = W_NEG1;
      end
      4'd10: begin
        c.mul_en = 1'b1;
      end
      4'd11: begin
        c.last = 1'b1;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/periodic_laplacian_stencil.sv */
// A query runs 12 program steps: nine reads from the single-port grid memory, a trailing
// accumulate, one multiply and one round step, in which the result word is loaded into the
// output register. A store writes the grid in its dispatch step and finishes. s_axis_tready
// stays low while the sequencer is busy, so a new word is taken only after a program ends.
// A new word is taken while a finished result still waits in the output register.
// Reset (rst_ni low, asynchronous) clears the sequencer, the output valid and the
// scale register (to 1.0); grid contents are undefined until written.
`default_nettype none
module periodic_laplacian_stencil (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // row[5:0], column[11:6], sample_value[35:12], zero
  input  wire logic [0:0]  s_axis_tuser,   // opcode[0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // laplacian_value[31:0]
  output logic [0:0]       m_axis_tuser    // saturated[0]
);

  logic [plap_pkg::ScaleW-1:0]          scale_q;
  logic                                 op_q;
  logic [plap_pkg::IdxW-1:0]            row_q, col_q;
  logic signed [plap_pkg::SampleW-1:0]  sample_q;
  logic                                 in_acc, cfg_wr, stall, load;
  logic                                 busy;
  logic [plap_pkg::PcW-1:0]             pc;
  plap_pkg::ctrl_t                      ctrl;
  logic signed [plap_pkg::ResW-1:0]     result;
  logic                                 sat;
  logic                                 out_valid_q, out_valid_d;
  logic [plap_pkg::ResW-1:0]            out_data_q;
  logic                                 out_sat_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? '0 : scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= plap_pkg::ScaleReset;
    end else if (cfg_wr) begin
      scale_q <= pwdata;
    end
  end

  assign s_axis_tready = !busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= s_axis_tuser[0];
      row_q    <= s_axis_tdata[5:0];
      col_q    <= s_axis_tdata[11:6];
      sample_q <= s_axis_tdata[35:12];
    end
  end

  // last step waits while an unclaimed result blocks the output register
  assign stall = ctrl.last && out_valid_q && !m_axis_tready;
  assign load  = ctrl.last && !stall;

  plap_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .is_store_i (op_q == plap_pkg::OP_STORE),
    .stall_i    (stall),
    .ctrl_o     (ctrl),
    .busy_o     (busy),
    .pc_o       (pc)
  );

  plap_datapath u_dp (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .is_store_i (op_q == plap_pkg::OP_STORE),
    .row_i      (row_q),
    .col_i      (col_q),
    .sample_i   (sample_q),
    .scale_i    (scale_q),
    .result_o   (result),
    .sat_o      (sat)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= result;
      out_sat_q  <= sat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

`ifndef SYNTHESIS
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc <= plap_pkg::LastStep)
    else $error("step counter past end of program");

  a_load_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> busy && op_q != plap_pkg::OP_STORE)
    else $error("result loaded outside a query");

  a_store_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser[0] == plap_pkg::OP_STORE) |=> !load)
    else $error("store produced a result");

  a_stall_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> busy && $stable(pc))
    else $error("sequencer moved while stalled");
`endif

endmodule
`default_nettype wire

/* rtl/plap_grid_mem.sv */
// Single-port grid sample memory with registered read data.
`default_nettype none
module plap_grid_mem (
  input  wire logic                            clk_i,
  input  wire logic                            we_i,
  input  wire logic                            re_i,
  input  wire logic [plap_pkg::AddrW-1:0]      addr_i,
  input  wire logic signed [plap_pkg::SampleW-1:0] wdata_i,
  output logic signed [plap_pkg::SampleW-1:0]  rdata_o
);

  logic signed [plap_pkg::SampleW-1:0] mem [plap_pkg::Depth];
  logic signed [plap_pkg::SampleW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/plap_seq.sv */
// Microcode sequencer: step counter over the control-word table.
`default_nettype none
module plap_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic            is_store_i,
  input  wire logic            stall_i,
  output plap_pkg::ctrl_t      ctrl_o,
  output logic                 busy_o,
  output logic [plap_pkg::PcW-1:0] pc_o
);

  logic                      busy_q, busy_d;
  logic [plap_pkg::PcW-1:0]  pc_q, pc_d;
  plap_pkg::ctrl_t           ctrl;
  logic                      done;

  always_comb begin
    ctrl = busy_q ? plap_pkg::ucode(pc_q) : '0;
    // conditional exit: a store ends after its dispatch step
    done = (ctrl.dispatch && is_store_i) || ctrl.last;
    busy_d = busy_q;
    pc_d   = pc_q;
    if (start_i) begin
      busy_d = 1'b1;
      pc_d   = '0;
    end else if (busy_q && !stall_i) begin
      if (done) begin
        busy_d = 1'b0;
        pc_d   = '0;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign ctrl_o = ctrl;
  assign busy_o = busy_q;
  assign pc_o   = pc_q;

endmodule
`default_nettype wire

/* rtl/plap_datapath.sv */
// Address generation, grid memory, weighted accumulator, scale multiply, round and saturate.
`default_nettype none
module plap_datapath (
  input  wire logic                                clk_i,
  input  wire plap_pkg::ctrl_t                     ctrl_i,
  input  wire logic                                is_store_i,
  input  wire logic [plap_pkg::IdxW-1:0]           row_i,
  input  wire logic [plap_pkg::IdxW-1:0]           col_i,
  input  wire logic signed [plap_pkg::SampleW-1:0] sample_i,
  input  wire logic [plap_pkg::ScaleW-1:0]         scale_i,
  output logic signed [plap_pkg::ResW-1:0]         result_o,
  output logic                                     sat_o
);

  logic [plap_pkg::IdxW-1:0]            row_n, col_n, row_off_x, col_off_x;
  logic                                 mem_we, mem_re;
  logic signed [plap_pkg::SampleW-1:0]  rdata;
  logic signed [plap_pkg::AccW-1:0]     ext, term, acc_q, acc_d;
  logic signed [plap_pkg::ProdW:0]      prod_full;
  logic signed [plap_pkg::ProdW-1:0]    prod_q, rnd_sum, shifted;
  logic                                 sat_hi, sat_lo;

  // offsets wrap naturally on the power-of-two grid
  assign row_off_x = {{(plap_pkg::IdxW-plap_pkg::OffW){ctrl_i.row_off[plap_pkg::OffW-1]}},
                      ctrl_i.row_off};
  assign col_off_x = {{(plap_pkg::IdxW-plap_pkg::OffW){ctrl_i.col_off[plap_pkg::OffW-1]}},
                      ctrl_i.col_off};
  assign row_n  = row_i + row_off_x;
  assign col_n  = col_i + col_off_x;
  assign mem_we = ctrl_i.dispatch && is_store_i;
  assign mem_re = ctrl_i.rd_en && !mem_we;

  plap_grid_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  ({row_n, col_n}),
    .wdata_i (sample_i),
    .rdata_o (rdata)
  );

  always_comb begin
    ext = {{(plap_pkg::AccW-plap_pkg::SampleW){rdata[plap_pkg::SampleW-1]}}, rdata};
    case (ctrl_i.weight)
      plap_pkg::W_NEG60: term = (ext <<< 2) - (ext <<< 6);
      plap_pkg::W_POS16: term = ext <<< 4;
      plap_pkg::W_NEG1:  term = -ext;
      default:           term = '0;
    endcase
    if (ctrl_i.acc_clr) begin
      acc_d = term;
    end else begin
      acc_d = acc_q + term;
    end
  end

  assign prod_full = $signed(acc_q) * $signed({1'b0, scale_i});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.weight != plap_pkg::W_NONE) begin
      acc_q <= acc_d;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= prod_full[plap_pkg::ProdW-1:0];
    end
  end

  // round to nearest, ties up: floor((p + 2^15) / 2^16)
  always_comb begin
    rnd_sum = prod_q + (plap_pkg::ProdW'(1) <<< (plap_pkg::RndShift - 1));
    shifted = rnd_sum >>> plap_pkg::RndShift;
    sat_hi  = !shifted[plap_pkg::ProdW-1] &&
              (|shifted[plap_pkg::ProdW-2:plap_pkg::ResW-1]);
    sat_lo  = shifted[plap_pkg::ProdW-1] &&
              !(&shifted[plap_pkg::ProdW-2:plap_pkg::ResW-1]);
    if (sat_hi) begin
      result_o = {1'b0, {(plap_pkg::ResW-1){1'b1}}};
    end else if (sat_lo) begin
      result_o = {1'b1, {(plap_pkg::ResW-1){1'b0}}};
    end else begin
      result_o = shifted[plap_pkg::ResW-1:0];
    end
    sat_o = sat_hi || sat_lo;
  end

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking testbench for the periodic fourth-order Laplacian stencil block.
`timescale 1ns / 100ps
module tb_top;
  import plap_pkg::*;

  typedef struct packed {
    logic signed [ResW-1:0] value;
    logic                   sat;
  } lap_result_t;

  localparam logic [2:0] ScaleAddr    = 3'd0;
  localparam logic [2:0] UnmappedAddr = 3'd4;  // no register behind this address
  localparam int         SettleCycles = 16;
  localparam int         IdleLimit    = 4000;
  localparam int         HoldCycles   = 150;
  localparam longint     ResMax       = 64'sh7FFF_FFFF;
  localparam longint     ResMin       = -64'sh8000_0000;

  // stencil taps: center, rows +1 +2 -1 -2, columns +1 +2 -1 -2
  localparam int TapRow[9]    = '{0, 1, 2, -1, -2, 0, 0, 0, 0};
  localparam int TapCol[9]    = '{0, 0, 0, 0, 0, 1, 2, -1, -2};
  localparam int TapWeight[9] = '{-60, 16, -1, 16, -1, 16, -1, 16, -1};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // row[5:0], column[11:6], sample_value[35:12], zero
  logic [0:0]  s_axis_tuser = '0;   // opcode[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // laplacian_value[31:0]
  logic [0:0]  m_axis_tuser;        // saturated[0]

  // shadow of the block
  logic signed [SampleW-1:0] grid_model [Depth];
  bit                        cell_written [Depth];
  logic [ScaleW-1:0]         scale_model = ScaleReset;

  lap_result_t pending_laplacians[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int mismatches = 0;
  int n_store = 0;
  int n_query = 0;
  int n_sat = 0;
  int n_scales = 1;
  int quiet_cycles = 0;

  periodic_laplacian_stencil uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int tap_addr(input logic [5:0] r, input logic [5:0] c, input int k);
    int rr;
    int cc;
    rr = (int'(r) + GridSize + TapRow[k]) % GridSize;
    cc = (int'(c) + GridSize + TapCol[k]) % GridSize;
    return rr * GridSize + cc;
  endfunction

  function automatic lap_result_t stencil_laplacian(input logic [5:0] r, input logic [5:0] c);
    longint acc;
    longint prod;
    longint q;
    lap_result_t res;
    acc = 0;
    for (int k = 0; k < 9; k++) begin
      acc += TapWeight[k] * longint'(grid_model[tap_addr(r, c, k)]);
    end
    prod = acc * longint'(scale_model);
    q = (prod + 64'sd32768) >>> 16;  // round half up
    res.sat = 1'b0;
    if (q > ResMax) begin
      q = ResMax;
      res.sat = 1'b1;
    end else if (q < ResMin) begin
      q = ResMin;
      res.sat = 1'b1;
    end
    res.value = q[ResW-1:0];
    return res;
  endfunction

  function automatic logic signed [SampleW-1:0] random_sample();
    case ($urandom_range(19))
      0: return {1'b1, {(SampleW-1){1'b0}}};
      1: return {1'b0, {(SampleW-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return SampleW'($urandom);
    endcase
  endfunction

  // mostly the wrap-around band near the edges, so stencils fill up quickly
  function automatic logic [5:0] random_index();
    int v;
    if ($urandom_range(99) < 70) begin
      v = $urandom_range(15);
      return (v < 8) ? 6'(v) : 6'(48 + v);
    end
    return 6'($urandom_range(63));
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // one input word; returns at the edge that accepted it, tvalid still high
  task automatic send_word(input opcode_e op, input logic [5:0] r, input logic [5:0] c,
                           input logic signed [SampleW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, v, c, r};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_STORE) begin
      grid_model[int'(r) * GridSize + int'(c)] = v;
      cell_written[int'(r) * GridSize + int'(c)] = 1'b1;
      n_store++;
    end else begin
      pending_laplacians.push_back(stencil_laplacian(r, c));
      n_query++;
    end
  endtask

  // fill any unwritten stencil cells, then ask for the Laplacian
  task automatic query_cell(input logic [5:0] r, input logic [5:0] c);
    int a;
    for (int k = 0; k < 9; k++) begin
      a = tap_addr(r, c, k);
      if (!cell_written[a]) begin
        send_word(OP_STORE, 6'(a / GridSize), 6'(a % GridSize), random_sample());
      end
    end
    send_word(OP_QUERY, r, c, random_sample());
  endtask

  task automatic store_cross(input logic [5:0] r, input logic [5:0] c,
                             input logic signed [SampleW-1:0] center_v,
                             input logic signed [SampleW-1:0] ring_v);
    int a;
    for (int k = 0; k < 9; k++) begin
      a = tap_addr(r, c, k);
      send_word(OP_STORE, 6'(a / GridSize), 6'(a % GridSize), (k == 0) ? center_v : ring_v);
    end
  endtask

  // wait for every result, then let a trailing store retire
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_laplacians.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ScaleAddr) scale_model = data;
  endtask

  task automatic mixed_traffic(input int n);
    int start;
    start = n_store + n_query;
    while (n_store + n_query - start < n) begin
      if ($urandom_range(99) < 30) begin
        send_word(OP_STORE, random_index(), random_index(), random_sample());
      end else begin
        query_cell(random_index(), random_index());
      end
    end
  endtask

  task automatic test_corner_stencils();
    logic signed [SampleW-1:0] s_min;
    logic signed [SampleW-1:0] s_max;
    s_min = {1'b1, {(SampleW-1){1'b0}}};
    s_max = {1'b0, {(SampleW-1){1'b1}}};
    store_cross(6'd0, 6'd0, s_min, s_max);
    send_word(OP_QUERY, 6'd0, 6'd0, s_max);
    store_cross(6'd63, 6'd63, s_max, s_min);
    send_word(OP_QUERY, 6'd63, 6'd63, s_min);
    send_word(OP_STORE, 6'd0, 6'd0, '0);
    send_word(OP_QUERY, 6'd0, 6'd0, '1);
    send_word(OP_STORE, 6'd63, 6'd63, '1);
    send_word(OP_QUERY, 6'd63, 6'd63, '0);
  endtask

  // output held off while the sender keeps pushing queries
  task automatic test_backpressure();
    int saved_idle;
    saved_idle = send_idle_pct;
    send_idle_pct = 0;
    hold_left = HoldCycles;
    repeat (20) query_cell(random_index(), random_index());
    drain();
    send_idle_pct = saved_idle;
  endtask

  task automatic test_scale_sweep();
    logic [31:0] scales[7];
    scales = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, $urandom, 32'd5461, ScaleReset};
    foreach (scales[i]) begin
      drain();
      apb_write(ScaleAddr, scales[i]);
      apb_write(UnmappedAddr, $urandom);
      n_scales++;
      mixed_traffic(22);
    end
  endtask

  // receiver: checks each result word, then picks tready for the next cycle
  always @(posedge clk_i) begin : result_check
    lap_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_laplacians.size() == 0) begin
        note_mismatch($sformatf("result %0d with no query pending", $signed(m_axis_tdata)));
      end else begin
        want = pending_laplacians.pop_front();
        if (want.sat) n_sat++;
        if (m_axis_tdata !== want.value) begin
          note_mismatch($sformatf("laplacian_value expected %0d, got %0d",
                                  want.value, $signed(m_axis_tdata)));
        end
        if (m_axis_tuser[0] !== want.sat) begin
          note_mismatch($sformatf("saturated expected %0b, got %0b",
                                  want.sat, m_axis_tuser[0]));
        end
      end
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("watchdog: no word moved for %0d cycles", IdleLimit);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 18;
    recv_stall_pct = 72;
    test_corner_stencils();
    mixed_traffic(140);

    send_idle_pct = 72;
    recv_stall_pct = 18;
    mixed_traffic(140);
    test_backpressure();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_scale_sweep();

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d stores and %0d queries (%0d saturated) over %0d scale settings,",
             n_store, n_query, n_sat, n_scales);
    $display("corner wrap, extreme samples, output hold-off and idle/stall mixes");
    if (mismatches == 0 && pending_laplacians.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/plap_pkg.sv
rtl/plap_grid_mem.sv
rtl/plap_seq.sv
rtl/plap_datapath.sv
rtl/periodic_laplacian_stencil.sv
bench/tb_top.sv
